FILE: rtl/core/oaid_pkg.sv
// ----------------------------------------------------------------------------
// oaid_pkg: shared types and constants for the ordered array block
// Command and status codes, table depth, and the control bundle that the
// top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package oaid_pkg;

    // table geometry
    localparam int C_DEPTH      = 64;
    localparam int C_DATA_W     = 32;
    localparam int C_COUNT_W    = 7;

    typedef logic [C_COUNT_W-1:0]      t_count;
    typedef logic signed [C_DATA_W-1:0] t_data;

    localparam t_count C_FULL_COUNT = t_count'(C_DEPTH);

    // request commands
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // broadcast to all cells for one accepted request
    typedef struct packed {
        logic   insert_en;   // insert passed its checks
        logic   delete_en;   // delete passed its checks
        logic   search_en;   // search request
        t_count pos;         // insert or delete position
        t_count len;         // length before the request
        t_data  value;       // insert or search value
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: rtl/core/oaid_cell.sv
// ----------------------------------------------------------------------------
// oaid_cell: one entry of the ordered array
// Holds one word, takes its lower neighbor on an insert shift and its upper
// neighbor on a delete shift, and compares itself against a search value.
// ----------------------------------------------------------------------------
`default_nettype none

module oaid_cell (
    input  wire logic                 i_clk,
    input  wire oaid_pkg::t_cell_ctrl i_ctrl,
    input  wire oaid_pkg::t_count     i_index,
    input  wire oaid_pkg::t_data      i_prev,
    input  wire oaid_pkg::t_data      i_next,
    output oaid_pkg::t_data           o_data,
    output logic                      o_match
);

    oaid_pkg::t_data r_data;
    oaid_pkg::t_data n_data;
    logic            r_match;

    // shift / load selection
    always_comb begin
        n_data = r_data;
        if (i_ctrl.insert_en) begin
            if (i_index > i_ctrl.pos) begin
                n_data = i_prev;
            end else if (i_index == i_ctrl.pos) begin
                n_data = i_ctrl.value;
            end
        end else if (i_ctrl.delete_en) begin
            if (i_index >= i_ctrl.pos) begin
                n_data = i_next;
            end
        end
    end

    // entry storage (undefined until written, no reset)
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // compare against old contents, only valid entries count
    always_ff @(posedge i_clk) begin
        if (i_ctrl.search_en) begin
            r_match <= (r_data == i_ctrl.value) && (i_index < i_ctrl.len);
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

`default_nettype wire

FILE: rtl/core/ordered_array_insert_delete_search.sv
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_search: ordered table with insert/delete/search
// Usage:
//   Requests enter on i_valid/o_stall with i_cmd, i_position, i_item_value.
//   A request is taken at a clock edge where i_valid is high and o_stall low.
//   Each request gives one result on o_valid/i_stall: o_status, o_found and
//   o_count (length after the request).
//   The table is a row of 64 cells; each holds one word and on every request
//   takes its neighbor's word (insert or delete shift) or its own, and on a
//   search compares its word against the search value in the same cycle.
//   The accepting edge updates the cells and captures the match in the match
//   stage; once the output register is free, the match reduction is loaded
//   into the output register, which raises o_valid.
//   Throughput: one request per cycle while results are taken.
//   When the receiver stalls, the result holds in the output register, one
//   more request sits in the match stage, and o_stall rises until the
//   output frees.
//   Reset empties the table (length zero); entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_array_insert_delete_search (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [6:0]  i_position,
    input  wire logic [31:0] i_item_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic             o_found,
    output logic [6:0]       o_count
);

    localparam int LP_DEPTH = oaid_pkg::C_DEPTH;

    oaid_pkg::t_count     r_len;
    oaid_pkg::t_count     n_len;
    oaid_pkg::t_status    n_status;
    oaid_pkg::t_cell_ctrl w_ctrl;
    oaid_pkg::t_cmd       w_cmd;
    logic                 w_accept;
    logic                 w_s1_move;
    logic                 w_ins_ok;
    logic                 w_del_ok;

    // match stage
    logic                 r_s1_valid;
    oaid_pkg::t_status    r_s1_status;
    logic                 r_s1_search;
    oaid_pkg::t_count     r_s1_count;

    // output register
    logic                 r_out_valid;
    oaid_pkg::t_status    r_out_status;
    logic                 r_out_found;
    oaid_pkg::t_count     r_out_count;

    oaid_pkg::t_data      w_data  [LP_DEPTH];
    logic [LP_DEPTH-1:0]  w_match;

    // handshake
    assign w_s1_move = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_s1_valid && !w_s1_move;
    assign w_accept  = i_valid && !o_stall;
    assign w_cmd     = oaid_pkg::t_cmd'(i_cmd);

    // request checks and new length
    always_comb begin
        n_len    = r_len;
        n_status = oaid_pkg::ST_OK;
        w_ins_ok = 1'b0;
        w_del_ok = 1'b0;
        case (w_cmd)
            oaid_pkg::CMD_INSERT: begin
                if (i_position > r_len) begin
                    n_status = oaid_pkg::ST_RANGE;
                end else if (r_len == oaid_pkg::C_FULL_COUNT) begin
                    n_status = oaid_pkg::ST_FULL;
                end else begin
                    w_ins_ok = 1'b1;
                    n_len    = r_len + 7'd1;
                end
            end
            oaid_pkg::CMD_DELETE: begin
                if (r_len == '0) begin
                    n_status = oaid_pkg::ST_EMPTY;
                end else if (i_position >= r_len) begin
                    n_status = oaid_pkg::ST_RANGE;
                end else begin
                    w_del_ok = 1'b1;
                    n_len    = r_len - 7'd1;
                end
            end
            oaid_pkg::CMD_SEARCH: begin
                n_len = r_len;
            end
            oaid_pkg::CMD_CLEAR: begin
                n_len = '0;
            end
            default: begin
                n_len = r_len;
            end
        endcase
    end

    // broadcast to the cell row
    always_comb begin
        w_ctrl.insert_en = w_accept && w_ins_ok;
        w_ctrl.delete_en = w_accept && w_del_ok;
        w_ctrl.search_en = w_accept && (w_cmd == oaid_pkg::CMD_SEARCH);
        w_ctrl.pos       = i_position;
        w_ctrl.len       = r_len;
        w_ctrl.value     = i_item_value;
    end

    // row of cells
    for (genvar g = 0; g < LP_DEPTH; g++) begin : g_cell
        oaid_pkg::t_data w_prev;
        oaid_pkg::t_data w_next;
        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_lo
            assign w_prev = w_data[g-1];
        end
        if (g == LP_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_hi
            assign w_next = w_data[g+1];
        end
        oaid_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_index (oaid_pkg::t_count'(g)),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    // length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (w_accept) begin
            r_len <= n_len;
        end
    end

    // match stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status <= n_status;
            r_s1_search <= (w_cmd == oaid_pkg::CMD_SEARCH);
            r_s1_count  <= n_len;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_status <= r_s1_status;
            r_out_found  <= r_s1_search && (|w_match);
            r_out_count  <= r_s1_count;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_found  = r_out_found;
    assign o_count  = r_out_count;

endmodule

`default_nettype wire

FILE: rtl/core/oaid_checker.sv
// ----------------------------------------------------------------------------
// oaid_checker: port-level checks for the ordered array block
// Watches the result channel and checks status, found and count agree.
// ----------------------------------------------------------------------------
`default_nettype none

module oaid_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_status,
    input wire logic        o_found,
    input wire logic [6:0]  o_count
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_found)
            && $stable(o_count))
        else $error("result changed while stalled");

    // found only comes with an ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_status == oaid_pkg::ST_OK)
        else $error("found with error status");

    // length never exceeds the table depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_count <= oaid_pkg::C_FULL_COUNT)
        else $error("count beyond depth");

    // full report only on a full table
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == oaid_pkg::ST_FULL |-> o_count == oaid_pkg::C_FULL_COUNT)
        else $error("full status on a table that is not full");

    // empty report only on an empty table
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == oaid_pkg::ST_EMPTY |-> o_count == '0)
        else $error("empty status on a table that is not empty");

endmodule

bind ordered_array_insert_delete_search oaid_checker u_oaid_checker (.*);

`default_nettype wire
